// ----- rtl/core/vt_escape_stripper_defines.svh -----
// ---------------------------------------------------------------------------
// VT escape stripper assertion macros
// Concurrent assertion wrappers; they expand to nothing when SYNTH is set.
// ---------------------------------------------------------------------------
`ifndef VT_ESCAPE_STRIPPER_DEFINES_SVH
`define VT_ESCAPE_STRIPPER_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication.
`define VTES_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vt_escape_stripper: check failed");

// Next-cycle implication.
`define VTES_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vt_escape_stripper: check failed");

`else

`define VTES_ASSERT_SAME(name, clk, rst_n, ante, cons)
`define VTES_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/core/vtes_pkg.sv -----
// ---------------------------------------------------------------------------
// VT escape stripper package
// Parser modes, byte codes and the beat type shared by the stripper modules.
// ---------------------------------------------------------------------------
package vtes_pkg;

    typedef enum logic [2:0] {
        MODE_TEXT    = 3'd0,
        MODE_ESC     = 3'd1,
        MODE_CSI     = 3'd2,
        MODE_OSC     = 3'd3,
        MODE_OSC_ESC = 3'd4
    } parse_mode_t;

    localparam logic [7:0] BYTE_BEL       = 8'h07;
    localparam logic [7:0] BYTE_TAB       = 8'h09;
    localparam logic [7:0] BYTE_LF        = 8'h0A;
    localparam logic [7:0] BYTE_CR        = 8'h0D;
    localparam logic [7:0] BYTE_ESC       = 8'h1B;
    localparam logic [7:0] BYTE_SP        = 8'h20;
    localparam logic [7:0] CSI_FINAL_MIN  = 8'h40;
    localparam logic [7:0] BYTE_LBRACKET  = 8'h5B;
    localparam logic [7:0] BYTE_BACKSLASH = 8'h5C;
    localparam logic [7:0] BYTE_RBRACKET  = 8'h5D;

    typedef struct packed {
        logic [7:0] data;
        logic       chunk_end;
    } beat_t;

    function automatic logic is_text_byte(input logic [7:0] b);
        return (b == BYTE_CR) || (b == BYTE_LF) || (b == BYTE_TAB) || (b >= BYTE_SP);
    endfunction

endpackage

// ----- rtl/core/vtes_in_stage.sv -----
// ---------------------------------------------------------------------------
// VT escape stripper input stage
// Registers one incoming beat and holds it until the parser takes it.
// ---------------------------------------------------------------------------
module vtes_in_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [7:0]     s_in_byte,
    input  logic           s_chunk_end,
    input  logic           advance,
    output logic           beat_valid,
    output vtes_pkg::beat_t beat
);
    import vtes_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    beat_t beat_reg;
    logic  load;

    assign s_ready = !valid_reg || advance;
    assign load    = s_valid && s_ready;

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            beat_reg.data      <= s_in_byte;
            beat_reg.chunk_end <= s_chunk_end;
        end
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule

// ----- rtl/core/vtes_parser.sv -----
// ---------------------------------------------------------------------------
// VT escape stripper parser
// Holds the parse mode and decides whether the current byte is kept.
// ---------------------------------------------------------------------------
module vtes_parser (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            advance,
    input  vtes_pkg::beat_t beat,
    output logic            keep
);
    import vtes_pkg::*;

    parse_mode_t mode_reg;
    parse_mode_t mode_next;
    parse_mode_t step_mode;
    parse_mode_t osc_mode;

    always_comb begin
        priority if (beat.data == BYTE_BEL) begin
            osc_mode = MODE_TEXT;
        end else if (beat.data == BYTE_ESC) begin
            osc_mode = MODE_OSC_ESC;
        end else begin
            osc_mode = MODE_OSC;
        end
    end

    always_comb begin
        keep      = 1'b0;
        step_mode = MODE_TEXT;
        unique case (mode_reg)
            MODE_ESC: begin
                if (beat.data == BYTE_LBRACKET) begin
                    step_mode = MODE_CSI;
                end else if (beat.data == BYTE_RBRACKET) begin
                    step_mode = MODE_OSC;
                end
            end
            MODE_CSI: begin
                if (beat.data < CSI_FINAL_MIN) begin
                    step_mode = MODE_CSI;
                end
            end
            MODE_OSC: begin
                step_mode = osc_mode;
            end
            MODE_OSC_ESC: begin
                step_mode = (beat.data == BYTE_BACKSLASH) ? MODE_TEXT : osc_mode;
            end
            default: begin
                if (beat.data == BYTE_ESC) begin
                    step_mode = MODE_ESC;
                end else begin
                    keep = is_text_byte(beat.data);
                end
            end
        endcase
        mode_next = beat.chunk_end ? MODE_TEXT : step_mode;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_TEXT;
        end else if (advance) begin
            mode_reg <= mode_next;
        end
    end

endmodule

// ----- rtl/core/vt_escape_stripper.sv -----
// ---------------------------------------------------------------------------
// VT escape stripper
// Filters a terminal byte stream, flagging each byte as readable text or not.
// ---------------------------------------------------------------------------
// One result beat comes out for every input beat, in order. m_valid for a beat
// rises once the beat has moved from the input register to the output
// register, when that register is free. Input register, parser and output
// register form a two-stage pipeline: one beat per cycle unless m_ready stalls;
// the single parse mode register is updated as each beat moves to the output.
// CSI, OSC and two-byte ESC sequences and stray control bytes are flagged
// with m_keep low; m_out_byte always copies the input byte. A beat with
// s_chunk_end high returns the parser to text mode after that byte.
// ---------------------------------------------------------------------------
`include "vt_escape_stripper_defines.svh"

module vt_escape_stripper (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_chunk_end,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_keep,
    output logic [7:0] m_out_byte,
    output logic       m_out_chunk_end
);
    import vtes_pkg::*;

    logic       beat_valid;
    beat_t      beat;
    logic       advance;
    logic       keep;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       m_keep_reg;
    logic [7:0] m_byte_reg;
    logic       m_chunk_end_reg;

    assign advance = beat_valid && (!m_valid_reg || m_ready);

    vtes_in_stage u_in_stage (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .s_chunk_end (s_chunk_end),
        .advance     (advance),
        .beat_valid  (beat_valid),
        .beat        (beat)
    );

    vtes_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .beat    (beat),
        .keep    (keep)
    );

    always_comb begin
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_keep_reg      <= keep;
            m_byte_reg      <= beat.data;
            m_chunk_end_reg <= beat.chunk_end;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_keep          = m_keep_reg;
    assign m_out_byte      = m_byte_reg;
    assign m_out_chunk_end = m_chunk_end_reg;

    `VTES_ASSERT_SAME(a_keep_is_text, aclk, aresetn, m_valid && m_keep, is_text_byte(m_out_byte))
    `VTES_ASSERT_SAME(a_esc_dropped, aclk, aresetn, m_valid && (m_out_byte == BYTE_ESC), !m_keep)
    `VTES_ASSERT_NEXT(a_advance_fills_out, aclk, aresetn, advance, m_valid)
    `VTES_ASSERT_SAME(a_no_overwrite, aclk, aresetn, m_valid && !m_ready, !advance)

endmodule

// ----- test/tb_vt_escape_stripper.sv -----
// ---------------------------------------------------------------------------
// VT escape stripper testbench
// Sends directed and random terminal bytes through the stripper. The input
// comes in bursts and the output stalls. Each result beat is predicted from
// a local copy of the parse mode. The keep flag, the byte and the chunk-end
// flag are then checked in order.
// ---------------------------------------------------------------------------
module tb_vt_escape_stripper;
    import vtes_pkg::*;

    typedef struct packed {
        logic       keep;
        logic [7:0] data;
        logic       chunk_end;
    } strip_result_t;

    localparam int unsigned RANDOM_BYTES = 1950;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte = 8'h00;
    logic       s_chunk_end = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_keep;
    logic [7:0] m_out_byte;
    logic       m_out_chunk_end;

    beat_t         term_bytes[$];
    strip_result_t strip_due[$];
    parse_mode_t   tracked_mode = MODE_TEXT;
    int unsigned   burst_left = 0;
    int unsigned   gap_left = 0;
    int unsigned   mismatches = 0;
    int unsigned   window_left = 0;
    int unsigned   stall_kind = 0;
    logic [15:0]   stall_mask = 16'hFFFF;
    logic [3:0]    stall_phase = 4'd0;

    vt_escape_stripper uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .s_chunk_end     (s_chunk_end),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_keep          (m_keep),
        .m_out_byte      (m_out_byte),
        .m_out_chunk_end (m_out_chunk_end)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic logic classify_byte(input parse_mode_t mode, input logic [7:0] b,
                                           output parse_mode_t next);
        logic keep;
        keep = 1'b0;
        next = MODE_TEXT;
        case (mode)
            MODE_ESC: begin
                if (b == BYTE_LBRACKET)
                    next = MODE_CSI;
                else if (b == BYTE_RBRACKET)
                    next = MODE_OSC;
            end
            MODE_CSI: begin
                if (b < CSI_FINAL_MIN)
                    next = MODE_CSI;
            end
            MODE_OSC, MODE_OSC_ESC: begin
                if (b == BYTE_ESC)
                    next = MODE_OSC_ESC;
                else if (b == BYTE_BEL || (mode == MODE_OSC_ESC && b == BYTE_BACKSLASH))
                    next = MODE_TEXT;
                else
                    next = MODE_OSC;
            end
            default: begin
                if (b == BYTE_ESC)
                    next = MODE_ESC;
                else
                    keep = (b == BYTE_CR) || (b == BYTE_LF) || (b == BYTE_TAB) || (b >= BYTE_SP);
            end
        endcase
        return keep;
    endfunction

    task automatic add_byte(input logic [7:0] b, input logic ce);
        beat_t beat;
        beat.data = b;
        beat.chunk_end = ce;
        term_bytes.push_back(beat);
    endtask

    task automatic add_stream_byte(input logic [7:0] b);
        add_byte(b, $urandom_range(0, 24) == 0);
    endtask

    // Sender: bursts of beats separated by random gaps.
    always @(posedge aclk) begin : drive
        logic        keep;
        parse_mode_t next_mode;
        beat_t       next_beat;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                keep = classify_byte(tracked_mode, s_in_byte, next_mode);
                strip_due.push_back({keep, s_in_byte, s_chunk_end});
                tracked_mode = s_chunk_end ? MODE_TEXT : next_mode;
            end
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (term_bytes.size() != 0) begin
                    next_beat = term_bytes.pop_front();
                    s_valid <= 1'b1;
                    s_in_byte <= next_beat.data;
                    s_chunk_end <= next_beat.chunk_end;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: switch between stall patterns every window.
    always @(posedge aclk) begin : stall
        if (window_left == 0) begin
            stall_kind = $urandom_range(0, 3);
            stall_mask = 16'($urandom) | 16'h0001;
            window_left = $urandom_range(20, 120);
        end else begin
            window_left--;
        end
        stall_phase <= stall_phase + 4'd1;
        case (stall_kind)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= stall_mask[stall_phase];
            default: m_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge aclk) begin : watch
        strip_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (strip_due.size() == 0) begin
                $error("out_byte: got 0x%02h with no beat outstanding", m_out_byte);
                mismatches++;
            end else begin
                want = strip_due.pop_front();
                if (m_keep !== want.keep) begin
                    $error("keep: expected %0d, actual %0d", want.keep, m_keep);
                    mismatches++;
                end
                if (m_out_byte !== want.data) begin
                    $error("out_byte: expected 0x%02h, actual 0x%02h", want.data, m_out_byte);
                    mismatches++;
                end
                if (m_out_chunk_end !== want.chunk_end) begin
                    $error("out_chunk_end: expected %0d, actual %0d",
                           want.chunk_end, m_out_chunk_end);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        int unsigned n;
        int unsigned k;
        int unsigned stop_at;
        logic [7:0]  b;

        // plain text extremes and control bytes
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(BYTE_CR, 1'b0);
        add_byte(BYTE_LF, 1'b0);
        add_byte(BYTE_TAB, 1'b0);
        add_byte(8'h1F, 1'b0);
        add_byte(BYTE_SP, 1'b0);
        // CSI with parameter at the top of its range, then the lowest final
        add_byte(BYTE_ESC, 1'b0);
        add_byte(BYTE_LBRACKET, 1'b0);
        add_byte(8'h3F, 1'b0);
        add_byte(CSI_FINAL_MIN, 1'b0);
        // OSC: ESC then another byte falls back to OSC, BEL ends it
        add_byte(BYTE_ESC, 1'b0);
        add_byte(BYTE_RBRACKET, 1'b0);
        add_byte(BYTE_ESC, 1'b0);
        add_byte(8'h41, 1'b0);
        add_byte(BYTE_BEL, 1'b0);
        // OSC: repeated ESC holds, backslash ends it
        add_byte(BYTE_ESC, 1'b0);
        add_byte(BYTE_RBRACKET, 1'b0);
        add_byte(BYTE_ESC, 1'b0);
        add_byte(BYTE_ESC, 1'b0);
        add_byte(BYTE_BACKSLASH, 1'b0);
        // two-byte escape whose second byte is ESC
        add_byte(BYTE_ESC, 1'b0);
        add_byte(BYTE_ESC, 1'b0);
        // chunk end cuts an escape; the next '[' is plain text
        add_byte(BYTE_ESC, 1'b1);
        add_byte(BYTE_LBRACKET, 1'b0);

        stop_at = term_bytes.size() + RANDOM_BYTES;
        while (term_bytes.size() < stop_at) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    n = $urandom_range(1, 12);
                    for (k = 0; k < n; k++) begin
                        if ($urandom_range(0, 7) == 0)
                            b = 8'($urandom_range(0, 31));
                        else
                            b = 8'($urandom_range(32, 255));
                        add_stream_byte(b);
                    end
                end
                3, 4: begin
                    add_stream_byte(BYTE_ESC);
                    add_stream_byte(BYTE_LBRACKET);
                    n = $urandom_range(0, 6);
                    for (k = 0; k < n; k++)
                        add_stream_byte(8'($urandom_range(0, 8'h3F)));
                    add_stream_byte(8'($urandom_range(CSI_FINAL_MIN, 8'hFF)));
                end
                5, 6: begin
                    add_stream_byte(BYTE_ESC);
                    add_stream_byte(BYTE_RBRACKET);
                    n = $urandom_range(0, 10);
                    for (k = 0; k < n; k++) begin
                        b = 8'($urandom_range(0, 255));
                        if (b == BYTE_BEL)
                            b = BYTE_SP;
                        if (b == BYTE_ESC && $urandom_range(0, 1) == 0) begin
                            add_stream_byte(BYTE_ESC);
                            b = 8'($urandom_range(8'h20, 8'h5B));
                        end
                        add_stream_byte(b);
                    end
                    if ($urandom_range(0, 1) == 0) begin
                        add_stream_byte(BYTE_BEL);
                    end else begin
                        add_stream_byte(BYTE_ESC);
                        add_stream_byte(BYTE_BACKSLASH);
                    end
                end
                7: begin
                    add_stream_byte(BYTE_ESC);
                    add_stream_byte(8'($urandom_range(0, 255)));
                end
                default: begin
                    n = $urandom_range(1, 8);
                    for (k = 0; k < n; k++)
                        add_stream_byte(8'($urandom_range(0, 255)));
                end
            endcase
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        while (term_bytes.size() != 0 || s_valid || strip_due.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #20000000;
        $display("Verification failed");
        $finish;
    end

endmodule
